// ===== rtl/nmts_pkg.sv =====
`timescale 1ns / 1ps
package nmts_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int MAX_DIM         = 256;
   localparam int DIM_W           = $clog2(MAX_DIM) + 1;
   localparam int CELL_W          = $clog2(MAX_DIM);
   localparam int SCALED_W        = COORD_FRAC_BITS + CELL_W;
   localparam int WFRAC_W         = COORD_FRAC_BITS + 1;
   localparam int WT_W            = 2 * COORD_FRAC_BITS + 1;
   localparam int SUM_SHIFT       = 2 * COORD_FRAC_BITS - 8;
   localparam int ADDR_W          = 16;
   localparam int STORE_DEPTH     = 1 << ADDR_W;
   localparam int TEXEL_W         = 24;
   localparam int CHAN_W          = 8;
   localparam int OUT_W           = 16;
   localparam int PROD_W          = CHAN_W + WT_W;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      REG_INTERP_MODE = 2'd0,
      REG_MAP_WIDTH   = 2'd1,
      REG_MAP_HEIGHT  = 2'd2
   } reg_index_type;

   typedef struct packed {
      op_type                      op;
      logic [3:0][ADDR_W-1:0]      addr;
      logic [3:0][WT_W-1:0]        wt;
      logic [TEXEL_W-1:0]          texel;
   } entry_type;

   typedef struct packed {
      logic interp_mode;
      logic [DIM_W-1:0] map_width;
      logic [DIM_W-1:0] map_height;
   } cfg_type;

endpackage

// ===== rtl/nmts_fifo.sv =====
`timescale 1ns / 1ps
module nmts_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nmts_pkg::entry_type push_word,
   output logic                pop_valid,
   output nmts_pkg::entry_type pop_word,
   output logic                almost_full
);
   import nmts_pkg::*;

   entry_type             mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [FIFO_PTR_W:0]   count_ff, count_in;
   logic                  pop;

   assign pop_valid   = (count_ff != '0);
   assign pop         = pop_valid;
   assign pop_word    = mem[head_ff];
   assign almost_full = (count_ff >= (FIFO_PTR_W+1)'(FIFO_DEPTH - 2));

   always_comb begin
      head_in  = head_ff + FIFO_PTR_W'(pop);
      tail_in  = tail_ff + FIFO_PTR_W'(push);
      count_in = count_ff + (FIFO_PTR_W+1)'(push) - (FIFO_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[tail_ff] <= push_word;
      end
   end

endmodule

// ===== rtl/nmts_front.sv =====
`timescale 1ns / 1ps
module nmts_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic                       req_type,
   input  logic [15:0]                req_texel_index,
   input  logic [7:0]                 req_texel_red,
   input  logic [7:0]                 req_texel_green,
   input  logic [7:0]                 req_texel_blue,
   input  logic [31:0]                req_coord_u,
   input  logic [31:0]                req_coord_v,
   input  nmts_pkg::cfg_type          cfg,
   output logic                       push,
   output nmts_pkg::entry_type        push_word
);
   import nmts_pkg::*;

   logic                   s1_valid_ff;
   op_type                 s1_op_ff;
   logic [SCALED_W-1:0]    s1_su_ff, s1_sv_ff, s1_su_in, s1_sv_in;
   logic [DIM_W-1:0]       s1_w_ff, w_clamp, h_clamp;
   logic                   s1_mode_ff;
   logic [ADDR_W-1:0]      s1_addr_ff;
   logic [TEXEL_W-1:0]     s1_texel_ff;

   logic [CELL_W-1:0]          x1, y1;
   logic [CELL_W:0]            x2, y2;
   logic [COORD_FRAC_BITS-1:0] rx, ry;
   logic [WFRAC_W-1:0]         rxe, rye, wx1, wy1;
   logic [2*DIM_W-1:0]         base1, base2;

   always_comb begin
      if (cfg.map_width == '0) w_clamp = DIM_W'(1);
      else if (cfg.map_width > DIM_W'(MAX_DIM)) w_clamp = DIM_W'(MAX_DIM);
      else w_clamp = cfg.map_width;
      if (cfg.map_height == '0) h_clamp = DIM_W'(1);
      else if (cfg.map_height > DIM_W'(MAX_DIM)) h_clamp = DIM_W'(MAX_DIM);
      else h_clamp = cfg.map_height;
      s1_su_in = SCALED_W'(req_coord_u[COORD_FRAC_BITS-1:0])
               * SCALED_W'(w_clamp - DIM_W'(1));
      s1_sv_in = SCALED_W'(req_coord_v[COORD_FRAC_BITS-1:0])
               * SCALED_W'(h_clamp - DIM_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op_type'(req_type);
         s1_su_ff    <= s1_su_in;
         s1_sv_ff    <= s1_sv_in;
         s1_w_ff     <= w_clamp;
         s1_mode_ff  <= cfg.interp_mode;
         s1_addr_ff  <= req_texel_index;
         s1_texel_ff <= {req_texel_blue, req_texel_green, req_texel_red};
      end
   end

   always_comb begin
      x1  = s1_su_ff[SCALED_W-1:COORD_FRAC_BITS];
      rx  = s1_su_ff[COORD_FRAC_BITS-1:0];
      y1  = s1_sv_ff[SCALED_W-1:COORD_FRAC_BITS];
      ry  = s1_sv_ff[COORD_FRAC_BITS-1:0];
      x2  = {1'b0, x1} + (CELL_W+1)'(rx != '0);
      y2  = {1'b0, y1} + (CELL_W+1)'(ry != '0);
      if (s1_mode_ff) begin
         rxe = {1'b0, rx};
         rye = {1'b0, ry};
      end else begin
         rxe = rx[COORD_FRAC_BITS-1] ? WFRAC_W'(1 << COORD_FRAC_BITS) : '0;
         rye = ry[COORD_FRAC_BITS-1] ? WFRAC_W'(1 << COORD_FRAC_BITS) : '0;
      end
      wx1   = WFRAC_W'(1 << COORD_FRAC_BITS) - rxe;
      wy1   = WFRAC_W'(1 << COORD_FRAC_BITS) - rye;
      base1 = (2*DIM_W)'(s1_w_ff) * (2*DIM_W)'(y1);
      base2 = (2*DIM_W)'(s1_w_ff) * (2*DIM_W)'(y2);

      push            = s1_valid_ff;
      push_word.op    = s1_op_ff;
      push_word.texel = s1_texel_ff;
      push_word.wt[0] = WT_W'(wx1) * WT_W'(wy1);
      push_word.wt[1] = WT_W'(rxe) * WT_W'(wy1);
      push_word.wt[2] = WT_W'(wx1) * WT_W'(rye);
      push_word.wt[3] = WT_W'(rxe) * WT_W'(rye);
      if (s1_op_ff == OP_WRITE) begin
         push_word.addr    = '0;
         push_word.addr[0] = s1_addr_ff;
      end else begin
         push_word.addr[0] = ADDR_W'(base1 + (2*DIM_W)'(x1));
         push_word.addr[1] = ADDR_W'(base1 + (2*DIM_W)'(x2));
         push_word.addr[2] = ADDR_W'(base2 + (2*DIM_W)'(x1));
         push_word.addr[3] = ADDR_W'(base2 + (2*DIM_W)'(x2));
      end
   end

endmodule

// ===== rtl/nmts_back.sv =====
`timescale 1ns / 1ps
module nmts_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  nmts_pkg::entry_type in_word,
   output logic                rsp_valid,
   output logic signed [15:0]  rsp_normal_x,
   output logic signed [15:0]  rsp_normal_y,
   output logic signed [15:0]  rsp_normal_z
);
   import nmts_pkg::*;

   logic [TEXEL_W-1:0] store_mem [4][STORE_DEPTH];

   logic                     b1_valid_ff, b2_valid_ff, out_valid_ff;
   logic [3:0][TEXEL_W-1:0]  b1_rd_ff;
   logic [3:0][WT_W-1:0]     b1_wt_ff;
   logic [PROD_W-1:0]        b2_prod_ff [3][4];
   logic [PROD_W+1:0]        sum [3];
   logic [2:0][OUT_W-1:0]    out_in, out_ff;
   logic                     sample, wr;

   assign sample = in_valid && (in_word.op == OP_SAMPLE);
   assign wr     = in_valid && (in_word.op == OP_WRITE);

   always_ff @(posedge clock) begin
      for (int b = 0; b < 4; b++) begin
         if (wr) begin
            store_mem[b][in_word.addr[0]] <= in_word.texel;
         end
         b1_rd_ff[b] <= store_mem[b][in_word.addr[b]];
      end
      b1_wt_ff <= in_word.wt;
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         for (int b = 0; b < 4; b++) begin
            b2_prod_ff[c][b] <= PROD_W'(b1_rd_ff[b][CHAN_W*c +: CHAN_W])
                              * PROD_W'(b1_wt_ff[b]);
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum[c] = (PROD_W+2)'(b2_prod_ff[c][0]) + (PROD_W+2)'(b2_prod_ff[c][1])
                + (PROD_W+2)'(b2_prod_ff[c][2]) + (PROD_W+2)'(b2_prod_ff[c][3]);
         out_in[c] = sum[c][SUM_SHIFT +: OUT_W] ^ OUT_W'(1 << (OUT_W - 1));
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= sample;
         b2_valid_ff  <= b1_valid_ff;
         out_valid_ff <= b2_valid_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_normal_x = $signed(out_ff[0]);
   assign rsp_normal_y = $signed(out_ff[1]);
   assign rsp_normal_z = $signed(out_ff[2]);

endmodule

// ===== rtl/normal_map_texture_sampler_core.sv =====
`timescale 1ns / 1ps
// Samples pass front stage, queue, bank read, products and output; writes give no result.
// One word per cycle unless busy, writes and samples mixed, set by the four-bank texel store.
// The output cannot be stalled; busy rises only if the front-to-back queue nears full.
// Reset: synchronous, clears pipeline control and queue, mode nearest, size 256 x 256.
// The texel store is not cleared; texels must be written before they are sampled.
module normal_map_texture_sampler_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_type,
   input  logic [15:0]                            req_texel_index,
   input  logic [7:0]                             req_texel_red,
   input  logic [7:0]                             req_texel_green,
   input  logic [7:0]                             req_texel_blue,
   input  logic [31:0]                            req_coord_u,
   input  logic [31:0]                            req_coord_v,
   output logic                                   rsp_valid,
   output logic signed [15:0]                     rsp_normal_x,
   output logic signed [15:0]                     rsp_normal_y,
   output logic signed [15:0]                     rsp_normal_z,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [nmts_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [nmts_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [nmts_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import nmts_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_sel;
   logic          csr_write, accept, push, pop_valid, almost_full;
   entry_type     push_word, pop_word;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.interp_mode <= 1'b0;
         cfg_ff.map_width   <= DIM_W'(MAX_DIM);
         cfg_ff.map_height  <= DIM_W'(MAX_DIM);
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_INTERP_MODE: cfg_ff.interp_mode <= csr_pwdata[0];
            REG_MAP_WIDTH:   cfg_ff.map_width   <= csr_pwdata[DIM_W-1:0];
            REG_MAP_HEIGHT:  cfg_ff.map_height  <= csr_pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_INTERP_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.interp_mode);
         REG_MAP_WIDTH:   csr_prdata = CSR_DATA_W'(cfg_ff.map_width);
         REG_MAP_HEIGHT:  csr_prdata = CSR_DATA_W'(cfg_ff.map_height);
         default:         csr_prdata = '0;
      endcase
   end

   assign busy   = almost_full;
   assign accept = start && !busy;

   nmts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_type        (req_type),
      .req_texel_index (req_texel_index),
      .req_texel_red   (req_texel_red),
      .req_texel_green (req_texel_green),
      .req_texel_blue  (req_texel_blue),
      .req_coord_u     (req_coord_u),
      .req_coord_v     (req_coord_v),
      .cfg             (cfg_ff),
      .push            (push),
      .push_word       (push_word)
   );

   nmts_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_word   (push_word),
      .pop_valid   (pop_valid),
      .pop_word    (pop_word),
      .almost_full (almost_full)
   );

   nmts_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pop_valid),
      .in_word      (pop_word),
      .rsp_valid    (rsp_valid),
      .rsp_normal_x (rsp_normal_x),
      .rsp_normal_y (rsp_normal_y),
      .rsp_normal_z (rsp_normal_z)
   );

endmodule

// ===== sim/normal_map_texture_sampler_core_tb.sv =====
`timescale 1ns / 1ps
module normal_map_texture_sampler_core_tb;
   import nmts_pkg::*;

   typedef struct {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } normal_type;

   typedef enum {ROW_WRITE, ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [15:0]        idx;
      logic [7:0]         r;
      logic [7:0]         g;
      logic [7:0]         b;
      logic [31:0]        u;
      logic [31:0]        v;
      bit                 typed;
      logic signed [15:0] ex;
      logic signed [15:0] ey;
      logic signed [15:0] ez;
   } row_type;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_type = 1'b0;
   logic [15:0] req_texel_index = '0;
   logic [7:0] req_texel_red = '0;
   logic [7:0] req_texel_green = '0;
   logic [7:0] req_texel_blue = '0;
   logic [31:0] req_coord_u = '0;
   logic [31:0] req_coord_v = '0;
   logic rsp_valid;
   logic signed [15:0] rsp_normal_x;
   logic signed [15:0] rsp_normal_y;
   logic signed [15:0] rsp_normal_z;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   normal_map_texture_sampler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_texel_index(req_texel_index),
      .req_texel_red(req_texel_red), .req_texel_green(req_texel_green),
      .req_texel_blue(req_texel_blue), .req_coord_u(req_coord_u),
      .req_coord_v(req_coord_v), .rsp_valid(rsp_valid),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .csr_psel(csr_psel), .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite), .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   logic [23:0] texel_mem [0:65535];
   bit          texel_written [0:65535];
   bit          mode_bilinear = 1'b0;
   logic [8:0]  map_w = 9'd256;
   logic [8:0]  map_h = 9'd256;
   normal_type  pending_normals [$];
   int          idle_pct = 0;
   int          failures = 0;
   int          words_sent = 0;
   int          normals_checked = 0;
   int          quiet_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(logic [8:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
   endfunction

   function automatic void locate(input logic [31:0] c, input int size,
                                  output int lo, output int hi, output int frac);
      int scaled;
      scaled = int'(c[15:0]) * (size - 1);
      lo = scaled >> 16;
      frac = scaled & 16'hFFFF;
      hi = (frac != 0) ? lo + 1 : lo;
   endfunction

   function automatic logic [15:0] texel_addr(int x, int y);
      int w;
      w = eff_dim(map_w);
      return 16'((x + w * y) & 16'hFFFF);
   endfunction

   function automatic normal_type sample_normal(logic [31:0] u, logic [31:0] v);
      int x1, x2, rx, y1, y2, ry, c;
      longint unsigned s, wx1, wy1, biased;
      longint unsigned ch [4];
      logic [15:0] comp [3];
      normal_type n;
      locate(u, eff_dim(map_w), x1, x2, rx);
      locate(v, eff_dim(map_h), y1, y2, ry);
      for (c = 0; c < 3; c++) begin
         ch[0] = 64'(texel_mem[texel_addr(x1, y1)][8*c +: 8]);
         ch[1] = 64'(texel_mem[texel_addr(x2, y1)][8*c +: 8]);
         ch[2] = 64'(texel_mem[texel_addr(x1, y2)][8*c +: 8]);
         ch[3] = 64'(texel_mem[texel_addr(x2, y2)][8*c +: 8]);
         if (mode_bilinear) begin
            wx1 = 64'(65536 - rx);
            wy1 = 64'(65536 - ry);
            s = ch[0] * (wx1 * wy1) + ch[1] * (64'(rx) * wy1)
              + ch[2] * (wx1 * 64'(ry)) + ch[3] * (64'(rx) * 64'(ry));
            biased = s >> SUM_SHIFT;
         end else begin
            biased = 64'(texel_mem[texel_addr(rx < 32768 ? x1 : x2,
                                              ry < 32768 ? y1 : y2)][8*c +: 8]);
            biased = biased << 8;
         end
         comp[c] = 16'(biased - 64'd32768);
      end
      n.x = comp[0];
      n.y = comp[1];
      n.z = comp[2];
      return n;
   endfunction

   task automatic idle_gap();
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_word(op_type op, logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [31:0] u, logic [31:0] v,
                            bit typed, normal_type want);
      bit held;
      start <= 1'b1;
      req_type <= op;
      req_texel_index <= idx;
      req_texel_red <= r;
      req_texel_green <= g;
      req_texel_blue <= b;
      req_coord_u <= u;
      req_coord_v <= v;
      do begin
         @(negedge clock);
         held = busy;
         @(posedge clock);
      end while (held);
      words_sent++;
      if (op == OP_WRITE) begin
         texel_mem[idx] = {b, g, r};
         texel_written[idx] = 1'b1;
      end else begin
         pending_normals.push_back(typed ? want : sample_normal(u, v));
      end
   endtask

   task automatic write_texel(logic [15:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      normal_type none;
      idle_gap();
      send_word(OP_WRITE, idx, r, g, b, $urandom(), $urandom(), 1'b0, none);
   endtask

   // fill any never-written neighbor first
   task automatic issue_sample(logic [31:0] u, logic [31:0] v, bit typed, normal_type want);
      int x1, x2, rx, y1, y2, ry;
      logic [15:0] a [4];
      locate(u, eff_dim(map_w), x1, x2, rx);
      locate(v, eff_dim(map_h), y1, y2, ry);
      a[0] = texel_addr(x1, y1);
      a[1] = texel_addr(x2, y1);
      a[2] = texel_addr(x1, y2);
      a[3] = texel_addr(x2, y2);
      foreach (a[i]) begin
         if (!texel_written[a[i]])
            write_texel(a[i], 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)));
      end
      idle_gap();
      send_word(OP_SAMPLE, 16'($urandom()), 8'($urandom()), 8'($urandom()),
                8'($urandom()), u, v, typed, want);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_normals.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type ri, logic [31:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(4 * ri);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (ri)
         REG_INTERP_MODE: mode_bilinear = value[0];
         REG_MAP_WIDTH:   map_w = value[8:0];
         REG_MAP_HEIGHT:  map_h = value[8:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_dim();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 0;
      if (pick == 1) return 256;
      if (pick == 2) return $urandom_range(511, 257);
      return $urandom_range(8, 1);
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] c;
      c = $urandom();
      case ($urandom_range(5))
         0: c[15:0] = 16'h0000;
         1: c[15:0] = 16'h8000;
         2: c[15:0] = 16'hFFFF;
         default: ;
      endcase
      return c;
   endfunction

   always @(negedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_normals.size() == 0) begin
            $error("normal with no sample outstanding: x=%0d y=%0d z=%0d",
                   rsp_normal_x, rsp_normal_y, rsp_normal_z);
            failures++;
         end else begin
            normal_type e;
            e = pending_normals.pop_front();
            normals_checked++;
            if (rsp_normal_x !== e.x) begin
               $error("normal_x expected %0d actual %0d", e.x, rsp_normal_x);
               failures++;
            end
            if (rsp_normal_y !== e.y) begin
               $error("normal_y expected %0d actual %0d", e.y, rsp_normal_y);
               failures++;
            end
            if (rsp_normal_z !== e.z) begin
               $error("normal_z expected %0d actual %0d", e.z, rsp_normal_z);
               failures++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      row_type plan [$];
      row_type row;
      normal_type want;
      int p, k;
      int pcts [3] = '{35, 75, 0};

      plan.push_back('{ROW_WRITE, 16'd0, 8'd255, 8'd0, 8'd128, 0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h0, 32'h0, 1, 32512, -32768, 0});
      plan.push_back('{ROW_WRITE, 16'hFFFF, 8'd0, 8'd255, 8'd1, 0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1,
                       -32768, 32512, -32512});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'hFFFF0000, 32'h00010000, 1,
                       32512, -32768, 0});
      plan.push_back('{ROW_WRITE, 16'hAAAA, 8'hAA, 8'h55, 8'hFF, 0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_WRITE, 16'h5555, 8'h55, 8'hAA, 8'h00, 0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h00008000, 32'h00008000, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h00007FFF, 32'h00007FFF, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_INTERP_MODE, 0, 0, 0, 32'd1, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h12348000, 32'h0000C000, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_WIDTH, 0, 0, 0, 32'd0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_HEIGHT, 0, 0, 0, 32'd511, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h0000ABCD, 32'hFFFF1234, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_WIDTH, 0, 0, 0, 32'd2, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_HEIGHT, 0, 0, 0, 32'd1, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h00008000, 32'h00008000, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_INTERP_MODE, 0, 0, 0, 32'd0, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_SAMPLE, 0, 0, 0, 0, 32'h00008000, 32'h00007FFF, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_WIDTH, 0, 0, 0, 32'd256, 0, 0, 0, 0, 0});
      plan.push_back('{ROW_CSR, REG_MAP_HEIGHT, 0, 0, 0, 32'd256, 0, 0, 0, 0, 0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         row = plan[i];
         want.x = row.ex;
         want.y = row.ey;
         want.z = row.ez;
         case (row.kind)
            ROW_WRITE:  write_texel(row.idx, row.r, row.g, row.b);
            ROW_SAMPLE: issue_sample(row.u, row.v, row.typed, want);
            ROW_CSR:    csr_write(reg_index_type'(row.idx[1:0]), row.u);
            default: ;
         endcase
      end

      for (p = 0; p < 3; p++) begin
         idle_pct = pcts[p];
         for (k = 0; words_sent < (p + 1) * 430; k++) begin
            if (k % 100 == 0) begin
               csr_write(REG_INTERP_MODE, $urandom_range(1));
               csr_write(REG_MAP_WIDTH, rand_dim());
               csr_write(REG_MAP_HEIGHT, rand_dim());
            end
            if ($urandom_range(9) < 7) begin
               issue_sample(rand_coord(), rand_coord(), 1'b0, want);
            end else if ($urandom_range(1) == 0) begin
               write_texel(16'($urandom()), 8'($urandom()), 8'($urandom()),
                           8'($urandom()));
            end else begin
               write_texel(texel_addr($urandom_range(eff_dim(map_w) - 1),
                                      $urandom_range(eff_dim(map_h) - 1)),
                           8'($urandom()), 8'($urandom()), 8'($urandom()));
            end
         end
      end

      drain();
      $display("Sent %0d words and checked %0d normals over nearest and bilinear modes,",
               words_sent, normals_checked);
      $display("map sizes from 1 to 256 including zero and oversize settings.");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
